### design/slpm_pkg.sv
// Shared constants, types and helpers for the sorted list pool manager.
package slpm_pkg;

  localparam int NODES    = 64;
  localparam int LISTS    = 16;
  localparam int KEY_BITS = 32;

  localparam int IDX_W  = $clog2(NODES);
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int LIST_W = $clog2(LISTS);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADID    = 2'd3;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    ptr_t             data;
  } ptr_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    key_t             data;
  } key_wr_t;

  typedef struct packed {
    key_t key;
    ptr_t next;
    ptr_t prev;
  } node_t;

  // Sign-extend the 32-bit input key, then fit it to KEY_BITS.
  function automatic key_t key_conv(input logic [31:0] k);
    logic [63:0] wide;
    wide = {{32{k[31]}}, k};
    return key_t'(wide[KEY_BITS-1:0]);
  endfunction

endpackage

### design/slpm_node_store.sv
// Node pool storage: key, next and prev memories with one registered read port.
module slpm_node_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [slpm_pkg::IDX_W-1:0] rd_addr,
  output slpm_pkg::node_t           rd_data,
  input  slpm_pkg::key_wr_t         key_wr,
  input  slpm_pkg::ptr_wr_t         next_wr,
  input  slpm_pkg::ptr_wr_t         prev_wr
);

  slpm_pkg::key_t key_mem  [slpm_pkg::NODES];
  slpm_pkg::ptr_t next_mem [slpm_pkg::NODES];
  slpm_pkg::ptr_t prev_mem [slpm_pkg::NODES];
  logic [slpm_pkg::NODES-1:0] next_vld;
  logic [slpm_pkg::NODES-1:0] prev_vld;

  always_ff @(posedge clk) begin
    if (key_wr.en) key_mem[key_wr.addr] <= key_wr.data;
    if (next_wr.en) next_mem[next_wr.addr] <= next_wr.data;
    if (prev_wr.en) prev_mem[prev_wr.addr] <= prev_wr.data;
  end

  // An entry never written reads as its reset link: next is i+1, prev is null.
  always_ff @(posedge clk) begin
    rd_data.key  <= key_mem[rd_addr];
    rd_data.next <= next_vld[rd_addr] ? next_mem[rd_addr]
                                      : slpm_pkg::PTR_W'(rd_addr) + slpm_pkg::PTR_W'(1);
    rd_data.prev <= prev_vld[rd_addr] ? prev_mem[rd_addr] : slpm_pkg::NIL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
      prev_vld <= '0;
    end else begin
      if (next_wr.en) next_vld[next_wr.addr] <= 1'b1;
      if (prev_wr.en) prev_vld[prev_wr.addr] <= 1'b1;
    end
  end

endmodule

### design/sorted_list_pool_manager.sv
// Top level: sequencer that walks and relinks sorted lists in the node pool.
//
// Each item is an insert or a delete of a signed key in one of lists 1..15,
// all drawn from a shared pool of 64 nodes. The block takes one item at a
// time and is not ready while it works. An item passes through a check of
// the list id and the pool, a walk of the list, the relinking states (pop,
// link1 and link2 for an insert, del1 and del2 for a found delete), a state
// that loads the result and the idle state. A bad list id or a full pool
// goes from the check straight to loading the result. The walk is bound by the
// single read port of the node memory, which yields one node per cycle. A
// result waits in an output register until taken, and the block holds the
// next result until that register is free.
module sorted_list_pool_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [3:0]  list_id,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  list_length,
  output logic [6:0]  free_count
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_LINK1 = 4'd4;
  localparam logic [3:0] S_LINK2 = 4'd5;
  localparam logic [3:0] S_DEL1  = 4'd6;
  localparam logic [3:0] S_DEL2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;

  logic                func_r;
  logic [3:0]          list_id_r;
  slpm_pkg::key_t      key_r;
  slpm_pkg::ptr_t      x_r, cur_r, p_r, nx_r;
  logic [1:0]          res_status;
  logic [slpm_pkg::CNT_W-1:0] res_len;

  slpm_pkg::ptr_t             free_head;
  logic [slpm_pkg::CNT_W-1:0] free_total;
  slpm_pkg::ptr_t             head [slpm_pkg::LISTS];
  logic [slpm_pkg::CNT_W-1:0] cnt  [slpm_pkg::LISTS];

  logic [slpm_pkg::LIST_W-1:0] lidx;
  logic                        bad_id;
  slpm_pkg::ptr_t              rd_ptr;
  slpm_pkg::node_t             rd;
  slpm_pkg::key_wr_t           key_wr;
  slpm_pkg::ptr_wr_t           next_wr, prev_wr;

  assign lidx   = slpm_pkg::LIST_W'(list_id_r);
  assign bad_id = (list_id_r == 4'd0) || (32'(list_id_r) >= slpm_pkg::LISTS);
  assign in_ready = (state == S_IDLE);

  slpm_node_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_ptr[slpm_pkg::IDX_W-1:0]),
    .rd_data (rd),
    .key_wr  (key_wr),
    .next_wr (next_wr),
    .prev_wr (prev_wr)
  );

  // Read address for the node that the next state looks at.
  always_comb begin
    case (state)
      S_CHECK: rd_ptr = func_r ? head[lidx] : free_head;
      S_POP:   rd_ptr = head[lidx];
      S_WALK:  rd_ptr = rd.next;
      default: rd_ptr = cur_r;
    endcase
  end

  always_comb begin
    key_wr  = '0;
    next_wr = '0;
    prev_wr = '0;
    case (state)
      S_POP: begin
        key_wr.en   = 1'b1;
        key_wr.addr = x_r[slpm_pkg::IDX_W-1:0];
        key_wr.data = key_r;
      end
      S_LINK1: begin
        next_wr = '{en: 1'b1, addr: x_r[slpm_pkg::IDX_W-1:0], data: cur_r};
        prev_wr = '{en: 1'b1, addr: x_r[slpm_pkg::IDX_W-1:0], data: p_r};
      end
      S_LINK2: begin
        prev_wr = '{en: cur_r != slpm_pkg::NIL, addr: cur_r[slpm_pkg::IDX_W-1:0],
                    data: x_r};
        next_wr = '{en: p_r != slpm_pkg::NIL, addr: p_r[slpm_pkg::IDX_W-1:0],
                    data: x_r};
      end
      S_DEL1: begin
        next_wr = '{en: p_r != slpm_pkg::NIL, addr: p_r[slpm_pkg::IDX_W-1:0],
                    data: nx_r};
        prev_wr = '{en: nx_r != slpm_pkg::NIL, addr: nx_r[slpm_pkg::IDX_W-1:0],
                    data: p_r};
      end
      S_DEL2: begin
        next_wr = '{en: 1'b1, addr: cur_r[slpm_pkg::IDX_W-1:0], data: free_head};
        prev_wr = '{en: 1'b1, addr: cur_r[slpm_pkg::IDX_W-1:0], data: slpm_pkg::NIL};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (bad_id) state_next = S_DONE;
        else if (!func_r) state_next = (free_head == slpm_pkg::NIL) ? S_DONE : S_POP;
        else state_next = (head[lidx] == slpm_pkg::NIL) ? S_DONE : S_WALK;
      end
      S_POP:   state_next = (head[lidx] == slpm_pkg::NIL) ? S_LINK1 : S_WALK;
      S_WALK: begin
        if (!func_r) begin
          if (rd.key >= key_r || rd.next == slpm_pkg::NIL) state_next = S_LINK1;
        end else begin
          if (rd.key == key_r) state_next = S_DEL1;
          else if (rd.next == slpm_pkg::NIL) state_next = S_DONE;
        end
      end
      S_LINK1: state_next = S_LINK2;
      S_LINK2: state_next = S_DONE;
      S_DEL1:  state_next = S_DEL2;
      S_DEL2:  state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_head  <= '0;
      free_total <= slpm_pkg::CNT_W'(slpm_pkg::NODES);
      for (int i = 0; i < slpm_pkg::LISTS; i++) begin
        head[i] <= slpm_pkg::NIL;
        cnt[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_POP: begin
          free_head  <= rd.next;
          free_total <= free_total - slpm_pkg::CNT_W'(1);
        end
        S_LINK2: begin
          if (p_r == slpm_pkg::NIL) head[lidx] <= x_r;
          cnt[lidx] <= cnt[lidx] + slpm_pkg::CNT_W'(1);
        end
        S_DEL1: if (p_r == slpm_pkg::NIL) head[lidx] <= nx_r;
        S_DEL2: begin
          free_head  <= cur_r;
          free_total <= free_total + slpm_pkg::CNT_W'(1);
          if (cnt[lidx] != '0) cnt[lidx] <= cnt[lidx] - slpm_pkg::CNT_W'(1);
        end
        S_DONE: if (!out_valid || out_ready) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers of the walk and the result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        func_r    <= func;
        list_id_r <= list_id;
        key_r     <= slpm_pkg::key_conv(key);
      end
      S_CHECK: begin
        x_r        <= free_head;
        cur_r      <= head[lidx];
        res_status <= bad_id ? slpm_pkg::ST_BADID :
                      func_r ? slpm_pkg::ST_NOTFOUND : slpm_pkg::ST_FULL;
        res_len    <= bad_id ? '0 : cnt[lidx];
      end
      S_POP: begin
        cur_r <= head[lidx];
        p_r   <= slpm_pkg::NIL;
      end
      S_WALK: begin
        if (!func_r) begin
          if (rd.key < key_r) begin
            p_r   <= cur_r;
            cur_r <= rd.next;
          end else begin
            p_r <= rd.prev;
          end
        end else if (rd.key == key_r) begin
          p_r  <= rd.prev;
          nx_r <= rd.next;
        end else begin
          cur_r <= rd.next;
        end
      end
      S_LINK2: begin
        res_status <= slpm_pkg::ST_OK;
        res_len    <= cnt[lidx] + slpm_pkg::CNT_W'(1);
      end
      S_DEL2: begin
        res_status <= slpm_pkg::ST_OK;
        res_len    <= (cnt[lidx] != '0) ? cnt[lidx] - slpm_pkg::CNT_W'(1) : '0;
      end
      S_DONE: if (!out_valid || out_ready) begin
        status      <= res_status;
        list_length <= 7'(res_len);
        free_count  <= 7'(free_total);
      end
      default: ;
    endcase
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_total) <= slpm_pkg::NODES)
    else $error("free count exceeds pool size");

  a_empty_free: assert property (@(posedge clk) disable iff (rst)
    (free_head == slpm_pkg::NIL) |-> (free_total == '0))
    else $error("free list empty but free count nonzero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while an item is in progress");

endmodule
